[hw/rtl/alr_pkg.sv]
package alr_pkg;

    // Sizes of the loop memory.
    localparam int LOOP_DEPTH  = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int REGIONS     = 3;
    localparam int MEM_DEPTH   = REGIONS * LOOP_DEPTH;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int LEN_W       = $clog2(LOOP_DEPTH + 1);
    localparam int POS_W       = $clog2(LOOP_DEPTH);
    localparam int REGION_W    = 2;
    localparam int MODE_W      = 3;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request codes.
    localparam logic [MODE_W-1:0] MODE_RECORD     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TICK       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_START_PLAY = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STOP_PLAY  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_START_REC  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_STOP_REC   = 3'd5;

    typedef logic [REGION_W-1:0] t_region;

    localparam t_region REGION_0 = 2'd0;
    localparam t_region REGION_1 = 2'd1;
    localparam t_region REGION_2 = 2'd2;

    // One memory operation handed from the front part to the back part.
    typedef struct packed {
        logic                   wr;
        logic [ADDR_W-1:0]      addr;
        logic [SAMPLE_BITS-1:0] data;
        logic                   last;
    } t_mem_op;

    // First address of a region.
    function automatic logic [ADDR_W-1:0] region_base(input t_region r);
        logic [ADDR_W-1:0] base;
        unique case (r)
            REGION_0: base = '0;
            REGION_1: base = ADDR_W'(LOOP_DEPTH);
            default:  base = ADDR_W'(2 * LOOP_DEPTH);
        endcase
        return base;
    endfunction

endpackage

[hw/rtl/alr_front.sv]
module alr_front
    import alr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_queue_full,
    input  logic [MODE_W-1:0]      i_mode,
    input  logic [SAMPLE_BITS-1:0] i_sample_in,
    output logic                   o_ready,
    output logic                   o_push,
    output t_mem_op                o_op
);

    logic [LEN_W-1:0] r_len0, r_len1, r_len2;
    logic [LEN_W-1:0] n_len0, n_len1, n_len2;
    t_region          r_play_reg, n_play_reg;
    t_region          r_done_reg, n_done_reg;
    t_region          r_rec_reg, n_rec_reg;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_recording, n_recording;
    logic             r_playing, n_playing;
    logic             r_pending, n_pending;

    logic             accept;
    logic [LEN_W-1:0] len_rec, len_play, len_wrap, pos_ext, pos_next;
    t_region          play_wrap, free_reg;
    logic [POS_W-1:0] pos_wrap;
    logic             pend_wrap;

    // Length of the region that a pointer names.
    function automatic logic [LEN_W-1:0] pick_len(input t_region r,
                                                  input logic [LEN_W-1:0] l0,
                                                  input logic [LEN_W-1:0] l1,
                                                  input logic [LEN_W-1:0] l2);
        logic [LEN_W-1:0] l;
        unique case (r)
            REGION_0: l = l0;
            REGION_1: l = l1;
            default:  l = l2;
        endcase
        return l;
    endfunction

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;

    // Lowest region that is neither played nor holds the last recording.
    always_comb begin
        priority if (r_play_reg != REGION_0 && r_done_reg != REGION_0) begin
            free_reg = REGION_0;
        end else if (r_play_reg != REGION_1 && r_done_reg != REGION_1) begin
            free_reg = REGION_1;
        end else begin
            free_reg = REGION_2;
        end
    end

    // A tick finds the position at or past the end: the loop wraps first.
    always_comb begin
        len_play  = pick_len(r_play_reg, r_len0, r_len1, r_len2);
        pos_ext   = LEN_W'(r_pos);
        play_wrap = r_play_reg;
        pos_wrap  = r_pos;
        pend_wrap = r_pending;
        if (pos_ext >= len_play) begin
            pos_wrap = '0;
            if (r_pending) begin
                play_wrap = r_done_reg;
                pend_wrap = 1'b0;
            end
        end
        len_wrap = pick_len(play_wrap, r_len0, r_len1, r_len2);
        pos_next = LEN_W'(pos_wrap) + LEN_W'(1);
        len_rec  = pick_len(r_rec_reg, r_len0, r_len1, r_len2);
    end

    // Request decode and state update.
    always_comb begin
        n_len0      = r_len0;
        n_len1      = r_len1;
        n_len2      = r_len2;
        n_play_reg  = r_play_reg;
        n_done_reg  = r_done_reg;
        n_rec_reg   = r_rec_reg;
        n_pos       = r_pos;
        n_recording = r_recording;
        n_playing   = r_playing;
        n_pending   = r_pending;
        o_push      = 1'b0;
        o_op.wr     = 1'b0;
        o_op.addr   = '0;
        o_op.data   = i_sample_in;
        o_op.last   = 1'b0;
        if (accept) begin
            unique case (i_mode)
                MODE_RECORD: begin
                    if (r_recording && len_rec < LEN_W'(LOOP_DEPTH)) begin
                        o_push    = 1'b1;
                        o_op.wr   = 1'b1;
                        o_op.addr = region_base(r_rec_reg) + ADDR_W'(len_rec);
                        unique case (r_rec_reg)
                            REGION_0: n_len0 = len_rec + LEN_W'(1);
                            REGION_1: n_len1 = len_rec + LEN_W'(1);
                            default:  n_len2 = len_rec + LEN_W'(1);
                        endcase
                    end
                end
                MODE_TICK: begin
                    if (r_playing) begin
                        n_play_reg = play_wrap;
                        n_pos      = pos_wrap;
                        n_pending  = pend_wrap;
                        if (len_wrap != '0 && LEN_W'(pos_wrap) < len_wrap) begin
                            o_push    = 1'b1;
                            o_op.addr = region_base(play_wrap) + ADDR_W'(pos_wrap);
                            if (pos_next >= len_wrap) begin
                                // Last sample of the loop: wrap and take a pending take.
                                o_op.last = 1'b1;
                                n_pos     = '0;
                                if (pend_wrap) begin
                                    n_play_reg = r_done_reg;
                                    n_pending  = 1'b0;
                                end
                            end else begin
                                n_pos = pos_next[POS_W-1:0];
                            end
                        end
                    end
                end
                MODE_START_PLAY: begin
                    if (!r_playing) begin
                        n_play_reg = r_done_reg;
                        n_playing  = 1'b1;
                        n_pos      = '0;
                        n_pending  = 1'b0;
                    end
                end
                MODE_STOP_PLAY: begin
                    n_playing = 1'b0;
                end
                MODE_START_REC: begin
                    if (!r_recording) begin
                        n_rec_reg   = free_reg;
                        n_recording = 1'b1;
                        unique case (free_reg)
                            REGION_0: n_len0 = '0;
                            REGION_1: n_len1 = '0;
                            default:  n_len2 = '0;
                        endcase
                    end
                end
                MODE_STOP_REC: begin
                    if (r_recording) begin
                        n_done_reg  = r_rec_reg;
                        n_recording = 1'b0;
                        n_pending   = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len0      <= '0;
            r_len1      <= '0;
            r_len2      <= '0;
            r_play_reg  <= REGION_0;
            r_done_reg  <= REGION_0;
            r_rec_reg   <= REGION_1;
            r_pos       <= '0;
            r_recording <= 1'b0;
            r_playing   <= 1'b0;
            r_pending   <= 1'b0;
        end else begin
            r_len0      <= n_len0;
            r_len1      <= n_len1;
            r_len2      <= n_len2;
            r_play_reg  <= n_play_reg;
            r_done_reg  <= n_done_reg;
            r_rec_reg   <= n_rec_reg;
            r_pos       <= n_pos;
            r_recording <= n_recording;
            r_playing   <= n_playing;
            r_pending   <= n_pending;
        end
    end

endmodule

[hw/rtl/alr_queue.sv]
module alr_queue
    import alr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_mem_op i_op,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_valid,
    output t_mem_op o_op
);

    t_mem_op           r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

endmodule

[hw/rtl/alr_back.sv]
module alr_back
    import alr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_op_valid,
    input  t_mem_op                i_op,
    input  logic                   i_ready,
    output logic                   o_pop,
    output logic                   o_valid,
    output logic [SAMPLE_BITS-1:0] o_sample_out,
    output logic                   o_loop_end
);

    logic [SAMPLE_BITS-1:0] r_mem [MEM_DEPTH];
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic                   r_s1_valid, r_s1_last;
    logic [SAMPLE_BITS-1:0] r_out_data;
    logic                   r_out_valid, r_out_last;
    logic                   out_free, s1_move, s1_free, do_read;

    // Read data advances into the output register whenever that has room.
    assign out_free = !r_out_valid || i_ready;
    assign s1_move  = r_s1_valid && out_free;
    assign s1_free  = !r_s1_valid || s1_move;
    assign o_pop    = i_op_valid && (i_op.wr || s1_free);
    assign do_read  = o_pop && !i_op.wr;

    // Loop memory: one write or one read per cycle.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_op.wr) begin
            r_mem[i_op.addr] <= i_op.data;
        end
        if (do_read) begin
            r_rd_data <= r_mem[i_op.addr];
            r_s1_last <= i_op.last;
        end
        if (s1_move) begin
            r_out_data <= r_rd_data;
            r_out_last <= r_s1_last;
        end
    end

    // Valid flags of the read stage and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (do_read) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out_data;
    assign o_loop_end   = r_out_last;

endmodule

[hw/rtl/audio_loop_recorder.sv]
// Mono audio looper over three sample regions that rotate through the roles of
// record region, last recording and playback region by pointer changes only.
// Each request (record sample, play tick, start or stop of play or record) is
// taken when the queue is not full, so one request per cycle is sustained while
// the queue has room; the front part updates region pointers, lengths and the
// play position at once and queues a single memory write or read, and the back
// part serves one memory access per cycle from the single-port loop memory
// while a read is not held up by a full read stage and output register. A play
// tick that yields a sample passes the queue, the registered memory read and the
// output register before the sample is presented. The memory needs no clearing
// after reset.
module audio_loop_recorder
    import alr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [MODE_W-1:0]      i_mode,
    input  logic [SAMPLE_BITS-1:0] i_sample_in,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [SAMPLE_BITS-1:0] o_sample_out,
    output logic                   o_loop_end
);

    logic    queue_full, push, pop, head_valid;
    t_mem_op push_op, head_op;

    // Request decode and looper state.
    alr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_queue_full (queue_full),
        .i_mode       (i_mode),
        .i_sample_in  (i_sample_in),
        .o_ready      (o_ready),
        .o_push       (push),
        .o_op         (push_op)
    );

    // Memory operations waiting for the back part.
    alr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (head_valid),
        .o_op    (head_op)
    );

    // Loop memory and result output.
    alr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op_valid   (head_valid),
        .i_op         (head_op),
        .i_ready      (i_ready),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_sample_out (o_sample_out),
        .o_loop_end   (o_loop_end)
    );

endmodule

[dv/audio_loop_recorder_chk.sv]
`timescale 1ns / 100ps

// Watches both channels of the looper, keeps a shadow copy of its state and
// compares every played sample with the one the shadow state says is due.
module audio_loop_recorder_chk
    import alr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    input  logic                   i_req_ready,
    input  logic [MODE_W-1:0]      i_req_mode,
    input  logic [SAMPLE_BITS-1:0] i_req_sample,
    input  logic                   i_play_valid,
    input  logic                   i_play_ready,
    input  logic [SAMPLE_BITS-1:0] i_play_sample,
    input  logic                   i_play_loop_end,
    output int                     o_fail_count,
    output int                     o_due_count
);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   loop_end;
    } t_played;

    // Shadow of the loop memory and the region bookkeeping.
    logic [SAMPLE_BITS-1:0] shadow_mem [MEM_DEPTH];
    logic [LEN_W-1:0]       shadow_len [REGIONS];
    t_region                play_region;
    t_region                last_take;
    t_region                rec_region;
    // Wide enough to hold a full loop length before it wraps.
    logic [LEN_W-1:0]       play_pos;
    logic                   recording;
    logic                   playing;
    logic                   take_pending;

    // Samples the block still owes, oldest first.
    t_played samples_due [$];

    // Back to the start of the loop; a waiting take becomes the played one.
    task automatic rewind_loop();
        play_pos = '0;
        if (take_pending) begin
            play_region  = last_take;
            take_pending = 1'b0;
        end
    endtask

    // Applies one request to the shadow state and queues the sample it plays.
    task automatic advance_looper(input logic [MODE_W-1:0] mode,
                                  input logic [SAMPLE_BITS-1:0] smp);
        logic [LEN_W-1:0] len;
        t_played          played;
        case (mode)
            MODE_RECORD: begin
                len = shadow_len[int'(rec_region)];
                // Samples past a full region are dropped.
                if (recording && len < LEN_W'(LOOP_DEPTH)) begin
                    shadow_mem[int'(rec_region) * LOOP_DEPTH + int'(len)] = smp;
                    shadow_len[int'(rec_region)] = len + 1'b1;
                end
            end
            MODE_TICK: begin
                if (playing) begin
                    if (play_pos >= shadow_len[int'(play_region)]) begin
                        rewind_loop();
                    end
                    len = shadow_len[int'(play_region)];
                    if (len != '0 && play_pos < len) begin
                        played.sample   =
                            shadow_mem[int'(play_region) * LOOP_DEPTH + int'(play_pos)];
                        play_pos        = play_pos + 1'b1;
                        played.loop_end = (play_pos >= len);
                        if (played.loop_end) begin
                            rewind_loop();
                        end
                        samples_due.push_back(played);
                    end
                end
            end
            MODE_START_PLAY: begin
                if (!playing) begin
                    play_region  = last_take;
                    playing      = 1'b1;
                    play_pos     = '0;
                    take_pending = 1'b0;
                end
            end
            MODE_STOP_PLAY: begin
                playing = 1'b0;
            end
            MODE_START_REC: begin
                // Lowest region that is neither played nor the last take.
                if (!recording) begin
                    if (play_region != REGION_0 && last_take != REGION_0) begin
                        rec_region = REGION_0;
                    end else if (play_region != REGION_1 && last_take != REGION_1) begin
                        rec_region = REGION_1;
                    end else begin
                        rec_region = REGION_2;
                    end
                    shadow_len[int'(rec_region)] = '0;
                    recording = 1'b1;
                end
            end
            MODE_STOP_REC: begin
                if (recording) begin
                    last_take    = rec_region;
                    recording    = 1'b0;
                    take_pending = 1'b1;
                end
            end
            default: begin
                // Unused codes are ignored.
            end
        endcase
    endtask

    // Results are checked before the request of the same edge is applied;
    // a tick never plays in the cycle it is taken.
    always @(posedge i_clk) begin : watch
        t_played played;
        if (!i_rst_n) begin
            foreach (shadow_len[r]) begin
                shadow_len[r] = '0;
            end
            play_region  = REGION_0;
            last_take    = REGION_0;
            rec_region   = REGION_1;
            play_pos     = '0;
            recording    = 1'b0;
            playing      = 1'b0;
            take_pending = 1'b0;
            samples_due.delete();
        end else begin
            if (i_play_valid && i_play_ready) begin
                if (samples_due.size() == 0) begin
                    $error("sample_out: nothing due, got %0d", $signed(i_play_sample));
                    o_fail_count++;
                end else begin
                    played = samples_due.pop_front();
                    if (i_play_sample !== played.sample) begin
                        $error("sample_out: expected %0d, got %0d",
                               $signed(played.sample), $signed(i_play_sample));
                        o_fail_count++;
                    end
                    if (i_play_loop_end !== played.loop_end) begin
                        $error("loop_end: expected %0b, got %0b",
                               played.loop_end, i_play_loop_end);
                        o_fail_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                advance_looper(i_req_mode, i_req_sample);
            end
        end
        o_due_count = samples_due.size();
    end

endmodule

[dv/audio_loop_recorder_tb.sv]
`timescale 1ns / 100ps

module audio_loop_recorder_tb;
    import alr_pkg::*;

    // Codes the block does not use.
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    localparam int HOLD_CYCLES     = 80;
    localparam int RANDOM_REQUESTS = 600;
    localparam int DRAIN_CYCLES    = 20;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic [MODE_W-1:0]      i_mode;
    logic [SAMPLE_BITS-1:0] i_sample_in;
    logic                   o_valid;
    logic                   i_ready;
    logic [SAMPLE_BITS-1:0] o_sample_out;
    logic                   o_loop_end;

    int fail_count;
    int due_count;
    int requests_sent;
    // Set while neither side may idle.
    bit steady;
    // Asks the receiver for one long hold-off; it reports when done.
    bit hold_req;
    bit hold_done;

    audio_loop_recorder u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_sample_in  (i_sample_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_sample_out (o_sample_out),
        .o_loop_end   (o_loop_end)
    );

    audio_loop_recorder_chk u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_ready     (o_ready),
        .i_req_mode      (i_mode),
        .i_req_sample    (i_sample_in),
        .i_play_valid    (o_valid),
        .i_play_ready    (i_ready),
        .i_play_sample   (o_sample_out),
        .i_play_loop_end (o_loop_end),
        .o_fail_count    (fail_count),
        .o_due_count     (due_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #4_000_000;
        $display("audio_loop_recorder_tb: errors");
        $finish;
    end

    // Receiver: mostly ready, one long hold-off on request, none while steady.
    initial begin
        i_ready   = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                i_ready <= steady || ($urandom_range(99) >= 9);
            end
        end
    end

    // Offers one request, called and returning just after a falling edge.
    task automatic offer_request(input logic [MODE_W-1:0] mode,
                                 input logic [SAMPLE_BITS-1:0] smp);
        while (!steady && $urandom_range(99) < 9) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_mode      <= mode;
        i_sample_in <= smp;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        if (mode != MODE_SPARE_6 && mode != MODE_SPARE_7) begin
            requests_sent++;
        end
    endtask

    task automatic play_ticks(input int count);
        repeat (count) offer_request(MODE_TICK, SAMPLE_BITS'($urandom));
    endtask

    initial begin : stimulus
        int take_len;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_mode      = MODE_RECORD;
        i_sample_in = '0;
        steady      = 1'b0;
        hold_req    = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Ignored requests: unused codes, a sample while idle, ticks while
        // stopped and commands that repeat the current state.
        offer_request(MODE_SPARE_6, 16'hFFFF);
        offer_request(MODE_SPARE_7, 16'h0000);
        offer_request(MODE_RECORD, 16'h7FFF);
        offer_request(MODE_TICK, 16'h0000);
        offer_request(MODE_STOP_PLAY, 16'h0000);
        offer_request(MODE_STOP_REC, 16'h0000);
        // Playing an empty region gives nothing.
        offer_request(MODE_START_PLAY, 16'h0000);
        offer_request(MODE_TICK, 16'h0000);
        // A short take with the extreme sample values.
        offer_request(MODE_START_REC, 16'h0000);
        offer_request(MODE_START_REC, 16'h0000);
        offer_request(MODE_RECORD, 16'h8000);
        offer_request(MODE_RECORD, 16'h7FFF);
        offer_request(MODE_RECORD, 16'h0000);
        offer_request(MODE_RECORD, 16'hFFFF);
        offer_request(MODE_RECORD, 16'h5555);
        offer_request(MODE_RECORD, 16'hAAAA);
        offer_request(MODE_STOP_REC, 16'h0000);
        // The empty loop wraps at once and picks up the pending take.
        play_ticks(4);
        offer_request(MODE_START_PLAY, 16'h0000);
        play_ticks(4);
        offer_request(MODE_STOP_PLAY, 16'h0000);
        offer_request(MODE_TICK, 16'h0000);

        // Fill a region past its end; the extra samples are dropped.
        offer_request(MODE_START_REC, 16'h0000);
        repeat (LOOP_DEPTH + 4) offer_request(MODE_RECORD, SAMPLE_BITS'($urandom));
        offer_request(MODE_STOP_REC, 16'h0000);
        offer_request(MODE_START_PLAY, 16'h0000);
        // The receiver stalls while ticks keep coming, so the block backs up.
        hold_req = 1'b1;
        play_ticks(100);
        steady = 1'b1;
        play_ticks(400);
        steady = 1'b0;
        // Through the end of the full loop and a little beyond.
        play_ticks(LOOP_DEPTH - 500 + 3);

        // Mostly complete takes with random content, some noise in between.
        requests_sent = 0;
        while (requests_sent < RANDOM_REQUESTS) begin
            if ($urandom_range(99) < 75) begin
                offer_request(MODE_START_REC, SAMPLE_BITS'($urandom));
                take_len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24);
                repeat (take_len) begin
                    offer_request(($urandom_range(4) == 0) ? MODE_TICK : MODE_RECORD,
                                  SAMPLE_BITS'($urandom));
                end
                offer_request(MODE_STOP_REC, SAMPLE_BITS'($urandom));
                if ($urandom_range(3) == 0) begin
                    offer_request(MODE_STOP_PLAY, SAMPLE_BITS'($urandom));
                    offer_request(MODE_START_PLAY, SAMPLE_BITS'($urandom));
                end
                play_ticks($urandom_range(0, 30));
            end else begin
                offer_request(MODE_W'($urandom_range(7)), SAMPLE_BITS'($urandom));
            end
        end
        i_valid <= 1'b0;

        // Drain the outstanding samples, then watch for stray ones.
        while (due_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && due_count == 0) begin
            $display("audio_loop_recorder_tb: clean");
        end else begin
            $display("audio_loop_recorder_tb: errors");
        end
        $finish;
    end

endmodule
